### rtl/first_fit_heap_allocator_assert.svh
// Assertion macros for the first-fit heap allocator checker.
// Depends on a clk and an active-low rst_n in the scope of use.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Clocked assertion, disabled during reset.
`define FFHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset as well.
`define FFHA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ffha_pkg.sv
// Shared types, constants and command codes of the first-fit heap allocator.
// No dependencies.
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int MAX_BLOCKS      = 64;
  localparam int IX_W            = $clog2(MAX_BLOCKS);
  localparam int IDX_W           = IX_W + 1;
  localparam int HEADER_BYTES    = 16;
  localparam int MIN_SPLIT_BYTES = 32;
  localparam logic [IDX_W-1:0] NIL = IDX_W'(MAX_BLOCKS);

  localparam logic [31:0] REGION0_RESET = 32'h4000_0000;
  localparam logic [31:0] REGION1_RESET = 32'h4010_C000;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] CFG_R0_BASE = 2'd0;
  localparam logic [1:0] CFG_R0_END  = 2'd1;
  localparam logic [1:0] CFG_R1_BASE = 2'd2;
  localparam logic [1:0] CFG_R1_END  = 2'd3;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_ZERO    = 3'd2,
    ST_IGNORED = 3'd3,
    ST_BADFREE = 3'd4
  } status_t;

  typedef struct packed {
    logic [31:0]      hdr;
    logic [31:0]      size;
    logic             idle;
    logic             async_rel;
    logic [IDX_W-1:0] nxt;
    logic [IDX_W-1:0] prv;
  } entry_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_RB0,
    OP_RB1,
    OP_RD_FIRST,
    OP_RD_NEXT,
    OP_LOAD_E,
    OP_GRANT_WHOLE,
    OP_RD_SPARE,
    OP_TAKE,
    OP_RD_ENEXT,
    OP_FIX_PREV,
    OP_GRANT_SPLIT,
    OP_FREE_E,
    OP_MERGE_N,
    OP_RD_EPREV,
    OP_MERGE_P,
    OP_WR_E,
    OP_WR_P,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic req_free;
    logic zero_size;
    logic ignored;
    logic first_nil;
    logic rd_fit;
    logic rd_match;
    logic rd_idle;
    logic rd_last;
    logic split_ok;
    logic e_next_nil;
    logic e_prev_nil;
    logic n_merge;
    logic p_merge;
    logic out_busy;
  } dp_sts_t;

endpackage

### rtl/ffha_if.sv
// Channel interfaces: request, result and configuration write.
// Depends on nothing but widths fixed here.
`timescale 1ns / 1ps

interface ffha_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] req_size;
  logic        async_release;
  logic [31:0] free_addr;
  modport source (output valid, req_type, req_size, async_release, free_addr, input ready);
  modport sink   (input valid, req_type, req_size, async_release, free_addr, output ready);
endinterface

interface ffha_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] alloc_addr;
  logic [31:0] granted_bytes;
  logic [31:0] idle_bytes;
  modport source (output valid, status, alloc_addr, granted_bytes, idle_bytes, input ready);
  modport sink   (input valid, status, alloc_addr, granted_bytes, idle_bytes, output ready);
endinterface

interface ffha_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/ffha_datapath.sv
// Datapath: region registers, block table memory, working entries and result register.
// Depends on ffha_pkg; driven by ffha_ctrl commands.
`timescale 1ns / 1ps

module ffha_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  ffha_pkg::dp_cmd_t   cmd,
  output ffha_pkg::dp_sts_t   sts,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_req_type,
  input  logic [15:0]         in_req_size,
  input  logic                in_async_release,
  input  logic [31:0]         in_free_addr,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic [31:0]         out_alloc_addr,
  output logic [31:0]         out_granted_bytes,
  output logic [31:0]         out_idle_bytes
);

  localparam int IX_W  = ffha_pkg::IX_W;
  localparam int IDX_W = ffha_pkg::IDX_W;
  localparam logic [31:0] HDR = 32'(ffha_pkg::HEADER_BYTES);

  logic [31:0] base_r [2];
  logic [31:0] end_r  [2];

  ffha_pkg::entry_t mem [ffha_pkg::MAX_BLOCKS];
  ffha_pkg::entry_t rdata_r;
  logic             rd_en;
  logic [IX_W-1:0]  rd_addr;
  logic             wr_en;
  logic [IX_W-1:0]  wr_addr;
  ffha_pkg::entry_t wr_data;

  logic [IDX_W-1:0] first_r, first_nxt;
  logic [IDX_W-1:0] spare_r, spare_nxt;
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] e_idx_r, e_idx_nxt;
  logic [IDX_W-1:0] p_idx_r, p_idx_nxt;
  logic [IDX_W-1:0] fix_idx_r, fix_idx_nxt;
  logic [31:0]      idle_r, idle_nxt;
  ffha_pkg::entry_t e_r, e_nxt;
  ffha_pkg::entry_t p_r, p_nxt;

  logic        req_type_r;
  logic [15:0] req_size_r;
  logic        req_async_r;
  logic [31:0] req_addr_r;
  logic [16:0] need;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_addr_r;
  logic [31:0] out_granted_r;
  logic [31:0] out_idle_r;

  logic [32:0] reg_hdr  [2];
  logic        reg_ok   [2];
  logic [31:0] reg_size [2];
  logic        reg_in   [2];
  logic [31:0] s_size;
  ffha_pkg::entry_t spare_ent;

  assign need = ({1'b0, req_size_r} + 17'd5) & ~17'd3;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      reg_hdr[r]  = (({1'b0, base_r[r]} + 33'd3) & ~33'd3) + 33'd4;
      reg_ok[r]   = {2'b00, end_r[r]} >= ({1'b0, reg_hdr[r]} + 34'(ffha_pkg::HEADER_BYTES));
      reg_size[r] = end_r[r] - reg_hdr[r][31:0] - HDR;
      reg_in[r]   = ({1'b0, req_addr_r} >= reg_hdr[r]) && (req_addr_r < end_r[r]);
    end
  end

  assign s_size = e_r.size - 32'(need) - HDR;

  always_comb begin
    spare_ent           = '0;
    spare_ent.nxt       = spare_r;
    spare_ent.prv       = ffha_pkg::NIL;
  end

  always_comb begin
    sts.req_free   = req_type_r == ffha_pkg::REQ_FREE;
    sts.zero_size  = req_size_r == 16'd0;
    sts.ignored    = (req_addr_r == 32'd0) || !(reg_in[0] || reg_in[1]);
    sts.first_nil  = first_r == ffha_pkg::NIL;
    sts.rd_fit     = rdata_r.idle && (rdata_r.size >= 32'(need));
    sts.rd_match   = (rdata_r.hdr + HDR) == req_addr_r;
    sts.rd_idle    = rdata_r.idle;
    sts.rd_last    = rdata_r.nxt == ffha_pkg::NIL;
    sts.split_ok   = ({1'b0, e_r.size} >= (33'(need) + 33'(ffha_pkg::MIN_SPLIT_BYTES)))
                     && (spare_r != ffha_pkg::NIL);
    sts.e_next_nil = e_r.nxt == ffha_pkg::NIL;
    sts.e_prev_nil = e_r.prv == ffha_pkg::NIL;
    sts.n_merge    = rdata_r.idle && ((e_r.hdr + HDR + e_r.size) == rdata_r.hdr);
    sts.p_merge    = rdata_r.idle && ((rdata_r.hdr + HDR + rdata_r.size) == e_r.hdr);
    sts.out_busy   = out_valid_r && !out_ready;
  end

  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    first_nxt   = first_r;
    spare_nxt   = spare_r;
    fill_nxt    = fill_r;
    cur_nxt     = cur_r;
    e_idx_nxt   = e_idx_r;
    p_idx_nxt   = p_idx_r;
    fix_idx_nxt = fix_idx_r;
    idle_nxt    = idle_r;
    e_nxt       = e_r;
    p_nxt       = p_r;
    unique case (cmd.op)
      ffha_pkg::OP_RB0: begin
        first_nxt = (reg_ok[0] || reg_ok[1]) ? '0 : ffha_pkg::NIL;
        spare_nxt = IDX_W'(reg_ok[0]) + IDX_W'(reg_ok[1]);
        fill_nxt  = IDX_W'(reg_ok[0]) + IDX_W'(reg_ok[1]);
        idle_nxt  = (reg_ok[0] ? reg_size[0] : 32'd0) + (reg_ok[1] ? reg_size[1] : 32'd0);
        wr_en     = reg_ok[0];
        wr_addr   = '0;
        wr_data   = '{hdr: reg_hdr[0][31:0], size: reg_size[0], idle: 1'b1, async_rel: 1'b0,
                      nxt: reg_ok[1] ? IDX_W'(1) : ffha_pkg::NIL, prv: ffha_pkg::NIL};
      end
      ffha_pkg::OP_RB1: begin
        wr_en   = reg_ok[1];
        wr_addr = reg_ok[0] ? IX_W'(1) : '0;
        wr_data = '{hdr: reg_hdr[1][31:0], size: reg_size[1], idle: 1'b1, async_rel: 1'b0,
                    nxt: ffha_pkg::NIL, prv: reg_ok[0] ? '0 : ffha_pkg::NIL};
      end
      ffha_pkg::OP_RD_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = first_r[IX_W-1:0];
        cur_nxt = first_r;
      end
      ffha_pkg::OP_RD_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = rdata_r.nxt[IX_W-1:0];
        cur_nxt = rdata_r.nxt;
      end
      ffha_pkg::OP_LOAD_E: begin
        e_nxt     = rdata_r;
        e_idx_nxt = cur_r;
      end
      ffha_pkg::OP_GRANT_WHOLE: begin
        e_nxt.idle      = 1'b0;
        e_nxt.async_rel = req_async_r;
        wr_en           = 1'b1;
        wr_addr         = e_idx_r[IX_W-1:0];
        wr_data         = e_nxt;
        idle_nxt        = idle_r - e_r.size;
      end
      ffha_pkg::OP_RD_SPARE: begin
        rd_en   = 1'b1;
        rd_addr = spare_r[IX_W-1:0];
      end
      ffha_pkg::OP_TAKE: begin
        wr_en       = 1'b1;
        wr_addr     = spare_r[IX_W-1:0];
        wr_data     = '{hdr: e_r.hdr + HDR + 32'(need), size: s_size, idle: 1'b1,
                        async_rel: 1'b0, nxt: e_r.nxt, prv: e_idx_r};
        fix_idx_nxt = spare_r;
        idle_nxt    = idle_r - e_r.size + s_size;
        if (spare_r < fill_r) begin
          spare_nxt = rdata_r.nxt;
        end else begin
          spare_nxt = spare_r + IDX_W'(1);
          fill_nxt  = spare_r + IDX_W'(1);
        end
      end
      ffha_pkg::OP_RD_ENEXT: begin
        rd_en   = 1'b1;
        rd_addr = e_r.nxt[IX_W-1:0];
      end
      ffha_pkg::OP_FIX_PREV: begin
        wr_en       = 1'b1;
        wr_addr     = e_r.nxt[IX_W-1:0];
        wr_data     = rdata_r;
        wr_data.prv = fix_idx_r;
      end
      ffha_pkg::OP_GRANT_SPLIT: begin
        e_nxt.nxt       = fix_idx_r;
        e_nxt.size      = 32'(need);
        e_nxt.idle      = 1'b0;
        e_nxt.async_rel = req_async_r;
        wr_en           = 1'b1;
        wr_addr         = e_idx_r[IX_W-1:0];
        wr_data         = e_nxt;
      end
      ffha_pkg::OP_FREE_E: begin
        e_nxt           = rdata_r;
        e_nxt.idle      = 1'b1;
        e_nxt.async_rel = 1'b0;
        e_idx_nxt       = cur_r;
        fix_idx_nxt     = cur_r;
        idle_nxt        = idle_r + rdata_r.size;
      end
      ffha_pkg::OP_MERGE_N: begin
        e_nxt.size = e_r.size + HDR + rdata_r.size;
        e_nxt.nxt  = rdata_r.nxt;
        idle_nxt   = idle_r + HDR;
        wr_en      = 1'b1;
        wr_addr    = e_r.nxt[IX_W-1:0];
        wr_data    = spare_ent;
        spare_nxt  = e_r.nxt;
      end
      ffha_pkg::OP_RD_EPREV: begin
        rd_en   = 1'b1;
        rd_addr = e_r.prv[IX_W-1:0];
      end
      ffha_pkg::OP_MERGE_P: begin
        p_nxt       = rdata_r;
        p_nxt.size  = rdata_r.size + HDR + e_r.size;
        p_nxt.nxt   = e_r.nxt;
        p_idx_nxt   = e_r.prv;
        fix_idx_nxt = e_r.prv;
        idle_nxt    = idle_r + HDR;
        wr_en       = 1'b1;
        wr_addr     = e_idx_r[IX_W-1:0];
        wr_data     = spare_ent;
        spare_nxt   = e_idx_r;
      end
      ffha_pkg::OP_WR_E: begin
        wr_en   = 1'b1;
        wr_addr = e_idx_r[IX_W-1:0];
        wr_data = e_r;
      end
      ffha_pkg::OP_WR_P: begin
        wr_en   = 1'b1;
        wr_addr = p_idx_r[IX_W-1:0];
        wr_data = p_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r[0]   <= ffha_pkg::REGION0_RESET;
      end_r[0]    <= ffha_pkg::REGION0_RESET;
      base_r[1]   <= ffha_pkg::REGION1_RESET;
      end_r[1]    <= ffha_pkg::REGION1_RESET;
      first_r     <= ffha_pkg::NIL;
      spare_r     <= '0;
      fill_r      <= '0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ffha_pkg::CFG_R0_BASE: base_r[0] <= cfg_data;
          ffha_pkg::CFG_R0_END:  end_r[0]  <= cfg_data;
          ffha_pkg::CFG_R1_BASE: base_r[1] <= cfg_data;
          ffha_pkg::CFG_R1_END:  end_r[1]  <= cfg_data;
          default: begin
          end
        endcase
      end
      first_r <= first_nxt;
      spare_r <= spare_nxt;
      fill_r  <= fill_nxt;
      idle_r  <= idle_nxt;
      if (cmd.op == ffha_pkg::OP_FINISH) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    e_idx_r   <= e_idx_nxt;
    p_idx_r   <= p_idx_nxt;
    fix_idx_r <= fix_idx_nxt;
    e_r       <= e_nxt;
    p_r       <= p_nxt;
    if (cmd.op == ffha_pkg::OP_ACCEPT) begin
      req_type_r  <= in_req_type;
      req_size_r  <= in_req_size;
      req_async_r <= in_async_release;
      req_addr_r  <= in_free_addr;
    end
    if (cmd.op == ffha_pkg::OP_FINISH) begin
      out_status_r <= cmd.status;
      out_idle_r   <= idle_r;
      if (cmd.status == ffha_pkg::ST_OK && req_type_r == ffha_pkg::REQ_ALLOC) begin
        out_addr_r    <= e_r.hdr + HDR;
        out_granted_r <= e_r.size;
      end else begin
        out_addr_r    <= '0;
        out_granted_r <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_alloc_addr    = out_addr_r;
  assign out_granted_bytes = out_granted_r;
  assign out_idle_bytes    = out_idle_r;

endmodule

### rtl/ffha_ctrl.sv
// Controller: sequences rebuild, first-fit walk, split and free with coalescing.
// Depends on ffha_pkg; commands ffha_datapath.
`timescale 1ns / 1ps

module ffha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  ffha_pkg::dp_sts_t sts,
  output ffha_pkg::dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_RB0, S_RB1, S_IDLE, S_DISPATCH,
    S_A_CHK, S_A_SPL, S_A_TAKE, S_A_RDN, S_A_FIX, S_A_GRANT,
    S_F_WALK, S_F_N, S_F_NCHK, S_F_NMID, S_F_NFIX,
    S_F_P, S_F_PCHK, S_F_PMID, S_F_PFIX, S_F_WE, S_F_WP,
    S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  ffha_pkg::status_t fin_r, fin_nxt;

  always_comb begin
    state_nxt  = state_r;
    fin_nxt    = fin_r;
    cmd.op     = ffha_pkg::OP_NONE;
    cmd.status = fin_r;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    unique case (state_r)
      S_RB0: begin
        cmd.op    = ffha_pkg::OP_RB0;
        state_nxt = S_RB1;
      end
      S_RB1: begin
        cmd.op    = ffha_pkg::OP_RB1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (cfg_valid) begin
          state_nxt = S_RB0;
        end else if (in_valid) begin
          cmd.op    = ffha_pkg::OP_ACCEPT;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FIN;
        if (!sts.req_free) begin
          if (sts.zero_size) begin
            fin_nxt = ffha_pkg::ST_ZERO;
          end else if (sts.first_nil) begin
            fin_nxt = ffha_pkg::ST_NOSPACE;
          end else begin
            cmd.op    = ffha_pkg::OP_RD_FIRST;
            state_nxt = S_A_CHK;
          end
        end else begin
          if (sts.ignored) begin
            fin_nxt = ffha_pkg::ST_IGNORED;
          end else if (sts.first_nil) begin
            fin_nxt = ffha_pkg::ST_BADFREE;
          end else begin
            cmd.op    = ffha_pkg::OP_RD_FIRST;
            state_nxt = S_F_WALK;
          end
        end
      end
      S_A_CHK: begin
        if (sts.rd_fit) begin
          cmd.op    = ffha_pkg::OP_LOAD_E;
          state_nxt = S_A_SPL;
        end else if (sts.rd_last) begin
          fin_nxt   = ffha_pkg::ST_NOSPACE;
          state_nxt = S_FIN;
        end else begin
          cmd.op = ffha_pkg::OP_RD_NEXT;
        end
      end
      S_A_SPL: begin
        if (sts.split_ok) begin
          cmd.op    = ffha_pkg::OP_RD_SPARE;
          state_nxt = S_A_TAKE;
        end else begin
          cmd.op    = ffha_pkg::OP_GRANT_WHOLE;
          fin_nxt   = ffha_pkg::ST_OK;
          state_nxt = S_FIN;
        end
      end
      S_A_TAKE: begin
        cmd.op    = ffha_pkg::OP_TAKE;
        state_nxt = sts.e_next_nil ? S_A_GRANT : S_A_RDN;
      end
      S_A_RDN: begin
        cmd.op    = ffha_pkg::OP_RD_ENEXT;
        state_nxt = S_A_FIX;
      end
      S_A_FIX: begin
        cmd.op    = ffha_pkg::OP_FIX_PREV;
        state_nxt = S_A_GRANT;
      end
      S_A_GRANT: begin
        cmd.op    = ffha_pkg::OP_GRANT_SPLIT;
        fin_nxt   = ffha_pkg::ST_OK;
        state_nxt = S_FIN;
      end
      S_F_WALK: begin
        if (sts.rd_match) begin
          if (sts.rd_idle) begin
            fin_nxt   = ffha_pkg::ST_BADFREE;
            state_nxt = S_FIN;
          end else begin
            cmd.op    = ffha_pkg::OP_FREE_E;
            state_nxt = S_F_N;
          end
        end else if (sts.rd_last) begin
          fin_nxt   = ffha_pkg::ST_BADFREE;
          state_nxt = S_FIN;
        end else begin
          cmd.op = ffha_pkg::OP_RD_NEXT;
        end
      end
      S_F_N: begin
        if (sts.e_next_nil) begin
          state_nxt = S_F_P;
        end else begin
          cmd.op    = ffha_pkg::OP_RD_ENEXT;
          state_nxt = S_F_NCHK;
        end
      end
      S_F_NCHK: begin
        if (sts.n_merge) begin
          cmd.op    = ffha_pkg::OP_MERGE_N;
          state_nxt = S_F_NMID;
        end else begin
          state_nxt = S_F_P;
        end
      end
      S_F_NMID: begin
        if (sts.e_next_nil) begin
          state_nxt = S_F_P;
        end else begin
          cmd.op    = ffha_pkg::OP_RD_ENEXT;
          state_nxt = S_F_NFIX;
        end
      end
      S_F_NFIX: begin
        cmd.op    = ffha_pkg::OP_FIX_PREV;
        state_nxt = S_F_P;
      end
      S_F_P: begin
        if (sts.e_prev_nil) begin
          state_nxt = S_F_WE;
        end else begin
          cmd.op    = ffha_pkg::OP_RD_EPREV;
          state_nxt = S_F_PCHK;
        end
      end
      S_F_PCHK: begin
        if (sts.p_merge) begin
          cmd.op    = ffha_pkg::OP_MERGE_P;
          state_nxt = S_F_PMID;
        end else begin
          state_nxt = S_F_WE;
        end
      end
      S_F_PMID: begin
        if (sts.e_next_nil) begin
          state_nxt = S_F_WP;
        end else begin
          cmd.op    = ffha_pkg::OP_RD_ENEXT;
          state_nxt = S_F_PFIX;
        end
      end
      S_F_PFIX: begin
        cmd.op    = ffha_pkg::OP_FIX_PREV;
        state_nxt = S_F_WP;
      end
      S_F_WE: begin
        cmd.op    = ffha_pkg::OP_WR_E;
        fin_nxt   = ffha_pkg::ST_OK;
        state_nxt = S_FIN;
      end
      S_F_WP: begin
        cmd.op    = ffha_pkg::OP_WR_P;
        fin_nxt   = ffha_pkg::ST_OK;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.op    = ffha_pkg::OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RB0;
      fin_r   <= ffha_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

### rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: controller plus datapath.
// Depends on ffha_pkg, ffha_if, ffha_ctrl and ffha_datapath.
//
//   channel  dir  beat carries
//   in_ch    in   req_type, req_size, async_release, free_addr
//   out_ch   out  status, alloc_addr, granted_bytes, idle_bytes
//   cfg_ch   in   index (0..3), data (32 bits)
//
// One request at a time; the block table is walked one descriptor per cycle
// through a single-port memory with registered read.
// After reset and after each configuration beat the table is rebuilt by states S_RB0 and S_RB1.
// A finished result waits in the output register; the next request is taken meanwhile.
// A request that finishes while the previous result still waits holds until out_ch.ready.
`timescale 1ns / 1ps

module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  ffha_in_if.sink     in_ch,
  ffha_out_if.source  out_ch,
  ffha_cfg_if.sink    cfg_ch
);

  ffha_pkg::dp_cmd_t cmd;
  ffha_pkg::dp_sts_t sts;
  logic in_ready;
  logic cfg_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = cfg_ready;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffha_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_ch.valid && cfg_ready),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .in_req_type       (in_ch.req_type),
    .in_req_size       (in_ch.req_size),
    .in_async_release  (in_ch.async_release),
    .in_free_addr      (in_ch.free_addr),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_alloc_addr    (out_ch.alloc_addr),
    .out_granted_bytes (out_ch.granted_bytes),
    .out_idle_bytes    (out_ch.idle_bytes)
  );

endmodule

### rtl/ffha_checker.sv
// Port-level checker for the first-fit heap allocator, bound to the top level.
// Depends on first_fit_heap_allocator_assert.svh and ffha_pkg.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_assert.svh"

module ffha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_alloc_addr,
  input logic [31:0] out_granted_bytes
);

  `FFHA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")
  `FFHA_ASSERT(a_fail_zero, out_valid && (out_status != ffha_pkg::ST_OK) |-> (out_alloc_addr == 32'd0) && (out_granted_bytes == 32'd0), "failed request carries an address")
  `FFHA_ASSERT(a_busy_after_req, in_valid && in_ready |=> !in_ready && !cfg_ready, "request taken while busy")
  `FFHA_ASSERT_ALWAYS(a_rebuild, !rst_n || (cfg_valid && cfg_ready) |=> !in_ready, "request taken during rebuild")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .cfg_valid         (cfg_ch.valid),
  .cfg_ready         (cfg_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_alloc_addr    (out_ch.alloc_addr),
  .out_granted_bytes (out_ch.granted_bytes)
);

### verif/tb_top.sv
// Self-checking bench for first_fit_heap_allocator: directed and random heap requests.
// Results are checked against a block-table predictor held in this file.
// Depends on rtl/ffha_pkg.sv, rtl/ffha_if.sv and the allocator RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int NONE = ffha_pkg::MAX_BLOCKS;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    ffha_pkg::status_t st;
    logic [31:0]       addr;
    logic [31:0]       granted;
    logic [31:0]       idle;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ffha_in_if  in_ch ();
  ffha_out_if out_ch ();
  ffha_cfg_if cfg_ch ();

  first_fit_heap_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #5 clk = ~clk;

  // heap table mirror
  logic [31:0] reg_lo [2];
  logic [31:0] reg_hi [2];
  logic [31:0] t_hdr  [ffha_pkg::MAX_BLOCKS];
  logic [31:0] t_size [ffha_pkg::MAX_BLOCKS];
  bit          t_idle [ffha_pkg::MAX_BLOCKS];
  bit          t_async[ffha_pkg::MAX_BLOCKS];
  int          t_next [ffha_pkg::MAX_BLOCKS];
  int          t_prev [ffha_pkg::MAX_BLOCKS];
  int          head_blk;
  int          spare_head;
  logic [31:0] idle_sum;

  heap_result_t pending_results[$];
  logic [31:0]  live_addrs[$];
  logic [31:0]  freed_addrs[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  hold_left = 0;
  bit  calm = 1'b0;
  int  quiet_cycles = 0;
  int  n_status[5];

  function automatic logic [63:0] region_hdr(int r);
    return ((64'(reg_lo[r]) + 64'd3) & ~64'd3) + 64'd4;
  endfunction

  function automatic int grab_spare();
    int e;
    e = spare_head;
    if (e < NONE) spare_head = t_next[e];
    return e;
  endfunction

  function automatic void return_spare(int e);
    t_hdr[e] = '0; t_size[e] = '0; t_idle[e] = 0; t_async[e] = 0;
    t_prev[e] = NONE;
    t_next[e] = spare_head;
    spare_head = e;
  endfunction

  function automatic void rebuild_table();
    int tail;
    int e;
    logic [63:0] h;
    tail = NONE;
    for (int i = 0; i < NONE; i++) begin
      t_hdr[i] = '0; t_size[i] = '0; t_idle[i] = 0; t_async[i] = 0;
      t_prev[i] = NONE; t_next[i] = i + 1;
    end
    spare_head = 0;
    head_blk = NONE;
    idle_sum = '0;
    for (int r = 0; r < 2; r++) begin
      h = region_hdr(r);
      if (64'(reg_hi[r]) < h + ffha_pkg::HEADER_BYTES) continue;
      e = grab_spare();
      t_hdr[e] = h[31:0];
      t_size[e] = 32'(64'(reg_hi[r]) - h - ffha_pkg::HEADER_BYTES);
      t_idle[e] = 1;
      t_prev[e] = tail;
      t_next[e] = NONE;
      if (tail >= NONE) head_blk = e;
      else t_next[tail] = e;
      tail = e;
      idle_sum += t_size[e];
    end
  endfunction

  function automatic bit addr_in_heap(logic [31:0] a);
    for (int r = 0; r < 2; r++)
      if (64'(a) >= region_hdr(r) && a < reg_hi[r]) return 1;
    return 0;
  endfunction

  function automatic void absorb(int a, int b);
    int n;
    n = t_next[b];
    t_size[a] += 32'(ffha_pkg::HEADER_BYTES) + t_size[b];
    idle_sum += 32'(ffha_pkg::HEADER_BYTES);
    t_next[a] = n;
    if (n < NONE) t_prev[n] = a;
    return_spare(b);
  endfunction

  function automatic heap_result_t predict_request(logic typ, logic [15:0] size,
                                                   logic async_rel, logic [31:0] faddr);
    heap_result_t res;
    logic [31:0] need;
    logic [31:0] hb;
    int e, s, n, p, steps;
    hb = 32'(ffha_pkg::HEADER_BYTES);
    res = '{ffha_pkg::ST_NOSPACE, 32'd0, 32'd0, 32'd0};
    if (typ == ffha_pkg::REQ_ALLOC) begin
      if (size == 0) res.st = ffha_pkg::ST_ZERO;
      else begin
        need = (32'(size) + 32'd5) & ~32'd3;
        e = head_blk;
        for (steps = 0; steps < NONE && e < NONE; steps++) begin
          if (t_idle[e] && t_size[e] >= need) begin
            if (64'(need) + ffha_pkg::MIN_SPLIT_BYTES <= 64'(t_size[e]) &&
                spare_head < NONE) begin
              s = grab_spare();
              n = t_next[e];
              t_hdr[s] = t_hdr[e] + hb + need;
              t_size[s] = t_size[e] - need - hb;
              t_idle[s] = 1; t_async[s] = 0;
              t_prev[s] = e; t_next[s] = n;
              if (n < NONE) t_prev[n] = s;
              t_next[e] = s;
              idle_sum = idle_sum - t_size[e] + t_size[s];
              t_size[e] = need;
            end else begin
              idle_sum -= t_size[e];
            end
            t_idle[e] = 0;
            t_async[e] = async_rel;
            res.st = ffha_pkg::ST_OK;
            res.addr = t_hdr[e] + hb;
            res.granted = t_size[e];
            break;
          end
          e = t_next[e];
        end
      end
    end else if (faddr == 0 || !addr_in_heap(faddr)) begin
      res.st = ffha_pkg::ST_IGNORED;
    end else begin
      e = head_blk;
      for (steps = 0; steps < NONE && e < NONE; steps++) begin
        if (t_hdr[e] + hb == faddr) break;
        e = t_next[e];
      end
      if (e >= NONE || t_idle[e]) res.st = ffha_pkg::ST_BADFREE;
      else begin
        res.st = ffha_pkg::ST_OK;
        t_idle[e] = 1; t_async[e] = 0;
        idle_sum += t_size[e];
        n = t_next[e];
        if (n < NONE && t_idle[n] && t_hdr[e] + hb + t_size[e] == t_hdr[n])
          absorb(e, n);
        p = t_prev[e];
        if (p < NONE && t_idle[p] && t_hdr[p] + hb + t_size[p] == t_hdr[e])
          absorb(p, e);
      end
    end
    res.idle = idle_sum;
    return res;
  endfunction

  task automatic send_req(logic typ, logic [15:0] size, logic async_rel, logic [31:0] faddr);
    heap_result_t res;
    if (!calm && $urandom_range(99) < 12) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.req_type = typ;
    in_ch.req_size = size;
    in_ch.async_release = async_rel;
    in_ch.free_addr = faddr;
    do @(posedge clk); while (!in_ch.ready);
    res = predict_request(typ, size, async_rel, faddr);
    pending_results.push_back(res);
    items_sent++;
    if (res.st == ffha_pkg::ST_OK) begin
      if (typ == ffha_pkg::REQ_ALLOC) live_addrs.push_back(res.addr);
      else begin
        foreach (live_addrs[i]) if (live_addrs[i] == faddr) begin
          live_addrs.delete(i);
          break;
        end
        freed_addrs.push_back(faddr);
        if (freed_addrs.size() > 16) void'(freed_addrs.pop_front());
      end
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic alloc(logic [15:0] size, logic async_rel = 1'b0);
    send_req(ffha_pkg::REQ_ALLOC, size, async_rel, $urandom);
  endtask

  task automatic release_addr(logic [31:0] a);
    send_req(ffha_pkg::REQ_FREE, 16'($urandom), 1'($urandom), a);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    drain();
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx[0]) reg_hi[idx[1]] = value;
    else reg_lo[idx[1]] = value;
    rebuild_table();
    live_addrs.delete();
    freed_addrs.delete();
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_regions(logic [31:0] b0, logic [31:0] e0, logic [31:0] b1,
                             logic [31:0] e1);
    cfg_write(ffha_pkg::CFG_R0_BASE, b0);
    cfg_write(ffha_pkg::CFG_R0_END, e0);
    cfg_write(ffha_pkg::CFG_R1_BASE, b1);
    cfg_write(ffha_pkg::CFG_R1_END, e1);
  endtask

  task automatic test_empty_heap();
    alloc(16'd1);
    alloc(16'hFFFF, 1'b1);
    release_addr(32'h4000_0010);
    release_addr(32'h0);
  endtask

  task automatic test_region_edges();
    // zero-byte block in region 0, region 1 one byte short of a header
    set_regions(32'h0000_1001, 32'h0000_1018, 32'h0000_2000, 32'h0000_2013);
    alloc(16'd1);
    release_addr(32'h0000_1008);
    release_addr(32'h0000_1018);
    set_regions(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0);
    alloc(16'd1);
    release_addr(32'hFFFF_FFFF);
  endtask

  task automatic test_alloc_free_merge();
    logic [31:0] a0, a1, a2;
    set_regions(32'h0000_2000, 32'h0000_2400, 32'h0000_3002, 32'h0000_3100);
    alloc(16'd0);
    alloc(16'hFFFF);
    alloc(16'd1, 1'b1);
    a0 = live_addrs[$];
    alloc(16'd13);
    a1 = live_addrs[$];
    alloc(16'd30, 1'b1);
    a2 = live_addrs[$];
    release_addr(a0);
    release_addr(a0);
    release_addr(a1 + 32'd4);
    release_addr(32'hFFFF_FFF0);
    release_addr(a2);
    release_addr(a1);
    alloc(16'd984);
    alloc(16'd200);
    alloc(16'd22);
    alloc(16'd1);
  endtask

  task automatic test_wrap_regions();
    set_regions(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    alloc(16'hFFFF, 1'b1);
    alloc(16'h8000);
    release_addr(live_addrs[0]);
    release_addr(32'hFFFF_FFFE);
  endtask

  task automatic random_phase(int count, int max_small);
    int pick;
    logic [31:0] a;
    for (int k = 0; k < count; k++) begin
      calm = (k >= count / 3 && k < count / 2);
      pick = $urandom_range(99);
      if (live_addrs.size() == 0 || pick < 50 - live_addrs.size() / 2) begin
        if ($urandom_range(99) < 5) alloc(16'd0);
        else if ($urandom_range(99) < 8) alloc(16'($urandom), 1'($urandom));
        else alloc(16'($urandom_range(1, max_small)), 1'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 75) a = live_addrs[$urandom_range(live_addrs.size() - 1)];
        else if (pick < 83 && freed_addrs.size() != 0)
          a = freed_addrs[$urandom_range(freed_addrs.size() - 1)];
        else if (pick < 90) a = live_addrs[0] + 32'($urandom_range(1, 12) * 4);
        else if (pick < 94) a = 32'h0;
        else a = $urandom;
        release_addr(a);
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_random();
    set_regions(32'h4000_0000, 32'h4000_1000, 32'h4010_C000, 32'h4010_C800);
    random_phase(450, 120);
    set_regions(32'h0000_0103, 32'h0000_0300, 32'h0000_0300, 32'h0000_0324);
    random_phase(250, 40);
    set_regions(32'h8000_0001, 32'h8004_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    random_phase(350, 4000);
  endtask

  task automatic test_backpressure();
    set_regions(32'h4000_0000, 32'h4000_1000, 32'h4010_C000, 32'h4010_C800);
    hold_left = 400;
    random_phase(165, 64);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = calm || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: status %0d", out_ch.status);
      end else begin
        want = pending_results.pop_front();
        if (want.st <= ffha_pkg::ST_BADFREE) n_status[want.st]++;
        if (out_ch.status !== want.st || out_ch.alloc_addr !== want.addr ||
            out_ch.granted_bytes !== want.granted || out_ch.idle_bytes !== want.idle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d addr %h grant %h idle %h, got %0d %h %h %h",
                     want.st, want.addr, want.granted, want.idle, out_ch.status,
                     out_ch.alloc_addr, out_ch.granted_bytes, out_ch.idle_bytes);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = ffha_pkg::REQ_ALLOC;
    in_ch.req_size = '0;
    in_ch.async_release = 1'b0;
    in_ch.free_addr = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ffha_pkg::CFG_R0_BASE;
    cfg_ch.data = '0;
    reg_lo[0] = ffha_pkg::REGION0_RESET; reg_hi[0] = ffha_pkg::REGION0_RESET;
    reg_lo[1] = ffha_pkg::REGION1_RESET; reg_hi[1] = ffha_pkg::REGION1_RESET;
    rebuild_table();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_empty_heap();
    test_region_edges();
    test_alloc_free_merge();
    test_wrap_regions();
    test_random();
    test_backpressure();

    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("covered %0d requests, %0d results: ok %0d, no space %0d, zero %0d,",
             items_sent, results_seen, n_status[0], n_status[1], n_status[2]);
    $display("ignored %0d, bad free %0d, mismatches %0d", n_status[3], n_status[4],
             mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
